// File: hw/rtl/lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared codes, widths and helpers for the line find and replace block.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int FIELD_LEN_W = 9;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_LOAD  = 2'd0;
    localparam t_action ACT_SUBST = 2'd1;
    localparam t_action ACT_READ  = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_REPLACED = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_RANGE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OLD_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_LEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd6;

    // Byte k of a sixteen-byte word, byte 0 in the low bits.
    function automatic logic [7:0] word_byte(input logic [127:0] w, input logic [3:0] k);
        word_byte = w[{k, 3'b000} +: 8];
    endfunction

endpackage

// File: hw/rtl/line_find_replace_first.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_find_replace_first
// A line of bytes in a RAM with load, read and first-match substitute.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   action, position, byte_in
//  out      from block o_out_valid / i_out_stall status, next_position,
//                                                line_length, byte_out
//  cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item is worked on at a time. A load goes from idle straight to the done
// state and a read passes through the read-wait state. A substitute reads and
// compares each byte of the search in turn (at most LINE_BYTES * WORD_BYTES
// compares), then moves each tail byte with a read and a write and writes the
// new-word bytes, all through the single RAM read and write port. Reset clears
// the line length and the output valid flag and sets the configuration registers
// to their defaults; the RAM is left as is. The result sits in an output register,
// so a stall on the output only holds the block once the next result is ready and the register is still full.
module line_find_replace_first #(
    parameter int LINE_BYTES = 256,
    parameter int WORD_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lfr_pkg::t_action               i_action,
    input  logic [7:0]                     i_position,
    input  logic [7:0]                     i_byte_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lfr_pkg::t_status               o_status,
    output logic [8:0]                     o_next_position,
    output logic [8:0]                     o_line_length,
    output logic [7:0]                     o_byte_out,
    input  logic                           i_cfg_we,
    input  logic [lfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_BYTES);
    // Wide enough for any index plus a word length and for the 9-bit fields.
    localparam int CW = (AW + 2 > 10) ? AW + 2 : 10;
    localparam int KW = $clog2(WORD_BYTES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_MRD  = 4'd3;
    localparam logic [3:0] S_MWR  = 4'd4;
    localparam logic [3:0] S_NWR  = 4'd5;
    localparam logic [3:0] S_RDW  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    // Configuration registers.
    logic [127:0] r_old_word, r_new_word;
    logic [4:0]   r_old_len, r_new_len;
    logic [8:0]   r_max_len;

    logic [3:0]      r_state, n_state;
    logic [8:0]      r_len, n_len;
    logic [CW-1:0]   r_i, n_i;
    logic [KW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_at, n_at;
    logic [CW-1:0]   r_src, n_src;
    logic [CW-1:0]   r_dst, n_dst;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_newlen, n_newlen;
    logic            r_back, n_back;
    lfr_pkg::t_status r_res_status, n_res_status;
    logic [8:0]      r_res_next, n_res_next;
    logic [7:0]      r_res_byte, n_res_byte;
    logic            r_out_valid, n_out_valid;
    lfr_pkg::t_status r_out_status, n_out_status;
    logic [8:0]      r_out_next, n_out_next;
    logic [8:0]      r_out_len, n_out_len;
    logic [7:0]      r_out_byte, n_out_byte;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    logic [KW-1:0]   ol, nl;
    logic [CW-1:0]   ol_w, nl_w, len_w, pos_w, found_len, tail;
    logic            out_free;

    lfr_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Word lengths above the word capacity saturate.
    assign ol   = (r_old_len > WORD_BYTES) ? KW'(WORD_BYTES) : KW'(r_old_len);
    assign nl   = (r_new_len > WORD_BYTES) ? KW'(WORD_BYTES) : KW'(r_new_len);
    assign ol_w  = CW'(ol);
    assign nl_w  = CW'(nl);
    assign len_w = CW'(r_len);
    assign pos_w = CW'(i_position);
    assign found_len = len_w - ol_w + nl_w;
    assign tail      = len_w - r_i - ol_w;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_next_position = r_out_next;
    assign o_line_length   = r_out_len;
    assign o_byte_out      = r_out_byte;

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_i          = r_i;
        n_k          = r_k;
        n_at         = r_at;
        n_src        = r_src;
        n_dst        = r_dst;
        n_cnt        = r_cnt;
        n_newlen     = r_newlen;
        n_back       = r_back;
        n_res_status = r_res_status;
        n_res_next   = r_res_next;
        n_res_byte   = r_res_byte;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_next   = r_out_next;
        n_out_len    = r_out_len;
        n_out_byte   = r_out_byte;
        ram_we       = 1'b0;
        ram_waddr    = AW'(pos_w);
        ram_wdata    = i_byte_in;
        ram_raddr    = AW'(pos_w);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_status = lfr_pkg::ST_OK;
                    n_res_next   = 9'd0;
                    n_res_byte   = 8'd0;
                    n_state      = S_DONE;
                    unique case (i_action)
                        lfr_pkg::ACT_LOAD: begin
                            if (pos_w < CW'(LINE_BYTES)) begin
                                ram_we = 1'b1;
                                n_len  = 9'(pos_w + CW'(1));
                            end else begin
                                n_res_status = lfr_pkg::ST_RANGE;
                            end
                        end
                        lfr_pkg::ACT_SUBST: begin
                            n_res_next = 9'(pos_w);
                            if (pos_w > len_w) begin
                                n_res_status = lfr_pkg::ST_RANGE;
                            end else begin
                                n_i     = pos_w;
                                n_k     = '0;
                                n_state = S_SRD;
                            end
                        end
                        lfr_pkg::ACT_READ: begin
                            if (pos_w < len_w && pos_w < CW'(LINE_BYTES)) begin
                                n_state = S_RDW;
                            end else begin
                                n_res_status = lfr_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_res_status = lfr_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                ram_raddr = AW'(r_i + CW'(r_k));
                if (r_i + ol_w > len_w) begin
                    n_state = S_DONE;
                end else if (r_k == ol) begin
                    // Match at r_i: check the length before touching the line.
                    n_at     = r_i;
                    n_newlen = found_len;
                    n_cnt    = tail;
                    if (found_len >= CW'(r_max_len) || found_len > CW'(LINE_BYTES)) begin
                        n_res_status = lfr_pkg::ST_OVERFLOW;
                        n_state      = S_DONE;
                    end else if (nl > ol) begin
                        // Growing: move the tail from its end downward.
                        n_back  = 1'b1;
                        n_src   = len_w - CW'(1);
                        n_dst   = found_len - CW'(1);
                        n_state = S_MRD;
                    end else begin
                        n_back  = 1'b0;
                        n_src   = r_i + ol_w;
                        n_dst   = r_i + nl_w;
                        n_state = S_MRD;
                    end
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (ram_rdata == lfr_pkg::word_byte(r_old_word, 4'(r_k))) begin
                    n_k = r_k + KW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                    n_k = '0;
                end
                n_state = S_SRD;
            end
            S_MRD: begin
                ram_raddr = AW'(r_src);
                if (r_cnt == '0) begin
                    n_k     = '0;
                    n_state = S_NWR;
                end else begin
                    n_state = S_MWR;
                end
            end
            S_MWR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_dst);
                ram_wdata = ram_rdata;
                n_cnt     = r_cnt - CW'(1);
                n_src     = r_back ? r_src - CW'(1) : r_src + CW'(1);
                n_dst     = r_back ? r_dst - CW'(1) : r_dst + CW'(1);
                n_state   = S_MRD;
            end
            S_NWR: begin
                ram_waddr = AW'(r_at + CW'(r_k));
                ram_wdata = lfr_pkg::word_byte(r_new_word, 4'(r_k));
                if (r_k == nl) begin
                    n_len        = 9'(r_newlen);
                    n_res_next   = 9'(r_at + nl_w);
                    n_res_status = lfr_pkg::ST_REPLACED;
                    n_state      = S_DONE;
                end else begin
                    ram_we = 1'b1;
                    n_k    = r_k + KW'(1);
                end
            end
            S_RDW: begin
                n_res_byte = ram_rdata;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_next   = r_res_next;
                    n_out_len    = r_len;
                    n_out_byte   = r_res_byte;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_old_word  <= '0;
            r_new_word  <= '0;
            r_old_len   <= 5'd1;
            r_new_len   <= 5'd0;
            r_max_len   <= 9'd256;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lfr_pkg::REG_OLD_LO:  r_old_word[63:0]   <= i_cfg_data;
                    lfr_pkg::REG_OLD_HI:  r_old_word[127:64] <= i_cfg_data;
                    lfr_pkg::REG_OLD_LEN: r_old_len          <= i_cfg_data[4:0];
                    lfr_pkg::REG_NEW_LO:  r_new_word[63:0]   <= i_cfg_data;
                    lfr_pkg::REG_NEW_HI:  r_new_word[127:64] <= i_cfg_data;
                    lfr_pkg::REG_NEW_LEN: r_new_len          <= i_cfg_data[4:0];
                    lfr_pkg::REG_MAX_LEN: r_max_len          <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_k          <= n_k;
        r_at         <= n_at;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_cnt        <= n_cnt;
        r_newlen     <= n_newlen;
        r_back       <= n_back;
        r_res_status <= n_res_status;
        r_res_next   <= n_res_next;
        r_res_byte   <= n_res_byte;
        r_out_status <= n_out_status;
        r_out_next   <= n_out_next;
        r_out_len    <= n_out_len;
        r_out_byte   <= n_out_byte;
    end

endmodule

// File: hw/rtl/lfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line find and replace block. A directed table
// covers reset values, range errors, overflow, empty and saturated words and
// a match at the line end. Random phases follow: each one loads a fresh
// configuration, builds a line from a small alphabet, then mixes substitutes,
// reads, loads and bad codes; each result is checked by the model or its row.
// ----------------------------------------------------------------------------
module tb_top;

    // Action code that the block does not know; it must answer a range status.
    localparam lfr_pkg::t_action ACT_BAD = 2'd3;
    localparam int      HOLD_CYCLES = 400;
    localparam int      IDLE_LIMIT  = 60000;
    localparam int      ITEM_TARGET = 580;

    typedef struct packed {
        lfr_pkg::t_status status;
        logic [8:0]       next_position;
        logic [8:0]       line_length;
        logic [7:0]       byte_out;
    } t_result;

    // One row of the directed table: either an item or a register write.
    typedef struct packed {
        bit                             is_cfg;
        lfr_pkg::t_action               action;
        logic [7:0]                     position;
        logic [7:0]                     byte_in;
        logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index;
        logic [lfr_pkg::CFG_DATA_W-1:0] cfg_data;
        bit                             typed;
        t_result                        res;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    lfr_pkg::t_action               i_action = lfr_pkg::ACT_LOAD;
    logic [7:0]                     i_position = '0;
    logic [7:0]                     i_byte_in = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    lfr_pkg::t_status               o_status;
    logic [8:0]                     o_next_position;
    logic [8:0]                     o_line_length;
    logic [7:0]                     o_byte_out;
    logic                           i_cfg_we = 1'b0;
    logic [lfr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    line_find_replace_first i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line model state: the bytes, which of them were ever written, the
    // length and the seven registers.
    logic [7:0]   line_bytes [256];
    bit           line_written [256];
    int unsigned  line_len;
    logic [127:0] old_word, new_word;
    logic [4:0]   old_len_reg, new_len_reg;
    logic [8:0]   max_len_reg;

    t_result pending_results[$];
    int      error_count = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_req = 0;
    int      hold_left = 0;

    // Computes the result of one item and updates the line model.
    task automatic model_line_item(input lfr_pkg::t_action act, input logic [7:0] pos,
                                   input logic [7:0] bin, output t_result r);
        int unsigned ol, nl, at, newlen, i, k;
        bit found, hit;
        logic [7:0] tail [256];
        r = '0;
        case (act)
            lfr_pkg::ACT_LOAD: begin
                line_bytes[pos] = bin;
                line_written[pos] = 1;
                line_len = pos + 1;
            end
            lfr_pkg::ACT_READ: begin
                if (pos < line_len) r.byte_out = line_bytes[pos];
                else r.status = lfr_pkg::ST_RANGE;
            end
            lfr_pkg::ACT_SUBST: begin
                // Word lengths above sixteen saturate.
                ol = (old_len_reg > 16) ? 16 : old_len_reg;
                nl = (new_len_reg > 16) ? 16 : new_len_reg;
                r.next_position = 9'(pos);
                found = 0;
                at = 0;
                if (pos > line_len) begin
                    r.status = lfr_pkg::ST_RANGE;
                end else begin
                    // An empty old word matches at the start position, and a
                    // match may end exactly at the line end.
                    for (i = pos; i + ol <= line_len && !found; i++) begin
                        hit = 1;
                        for (k = 0; k < ol; k++)
                            if (line_bytes[i + k] != old_word[k * 8 +: 8]) hit = 0;
                        if (hit) begin
                            found = 1;
                            at = i;
                        end
                    end
                    if (found) begin
                        newlen = line_len - ol + nl;
                        if (newlen >= max_len_reg || newlen > 256) begin
                            r.status = lfr_pkg::ST_OVERFLOW;
                        end else begin
                            for (i = 0; i < line_len - at - ol; i++)
                                tail[i] = line_bytes[at + ol + i];
                            for (i = 0; i < line_len - at - ol; i++)
                                line_bytes[at + nl + i] = tail[i];
                            for (k = 0; k < nl; k++)
                                line_bytes[at + k] = new_word[k * 8 +: 8];
                            for (i = 0; i < newlen; i++) line_written[i] = 1;
                            line_len = newlen;
                            r.status = lfr_pkg::ST_REPLACED;
                            r.next_position = 9'(at + nl);
                        end
                    end
                end
            end
            default: r.status = lfr_pkg::ST_RANGE;
        endcase
        r.line_length = 9'(line_len);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result checker: each result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_next_position !== want.next_position)
                    report("next_position", o_next_position, want.next_position);
                if (o_line_length !== want.line_length)
                    report("line_length", o_line_length, want.line_length);
                if (o_byte_out !== want.byte_out) report("byte_out", o_byte_out, want.byte_out);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so that the
    // output register fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog over cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_item(input lfr_pkg::t_action act, input logic [7:0] pos,
                             input logic [7:0] bin, input bit typed,
                             input t_result typed_res);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_action <= act;
        i_position <= pos;
        i_byte_in <= bin;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        model_line_item(act, pos, bin, r);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lfr_pkg::REG_OLD_LO:  old_word[63:0] = data;
            lfr_pkg::REG_OLD_HI:  old_word[127:64] = data;
            lfr_pkg::REG_OLD_LEN: old_len_reg = data[4:0];
            lfr_pkg::REG_NEW_LO:  new_word[63:0] = data;
            lfr_pkg::REG_NEW_HI:  new_word[127:64] = data;
            lfr_pkg::REG_NEW_LEN: new_len_reg = data[4:0];
            lfr_pkg::REG_MAX_LEN: max_len_reg = data[8:0];
            default: ;
        endcase
    endtask

    // Word bytes mostly come from the same small alphabet as the line, so
    // that matches are frequent.
    function automatic logic [63:0] alpha_bytes();
        logic [63:0] w;
        for (int k = 0; k < 8; k++)
            w[k * 8 +: 8] = ($urandom_range(9) < 8) ? 8'(8'h61 + $urandom_range(2))
                                                    : 8'($urandom);
        return w;
    endfunction

    function automatic logic [7:0] alpha_byte();
        return ($urandom_range(9) < 8) ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom);
    endfunction

    function automatic logic [63:0] rand_len();
        return ($urandom_range(9) == 0) ? $urandom_range(31, 17) : $urandom_range(16);
    endfunction

    // First position that was never written; loads stay at or below it so
    // that nothing below the line length is ever undefined.
    function automatic int first_hole();
        for (int i = 0; i < 256; i++)
            if (!line_written[i]) return i;
        return 255;
    endfunction

    localparam t_result NO_RES = '0;

    // Directed table. Typed rows carry results that follow from the reset values
    // and the rows before them; the rest are checked against the line model.
    t_row directed [] = '{
        '{0, lfr_pkg::ACT_READ,  8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_RANGE, 9'd0, 9'd0, 8'h00}},
        '{0, lfr_pkg::ACT_SUBST, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_OK, 9'd0, 9'd0, 8'h00}},
        '{0, lfr_pkg::ACT_SUBST, 8'd5, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_RANGE, 9'd5, 9'd0, 8'h00}},
        '{0, ACT_BAD,            8'd0, 8'hFF, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_RANGE, 9'd0, 9'd0, 8'h00}},
        '{0, lfr_pkg::ACT_LOAD,  8'd0, 8'hFF, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_OK, 9'd0, 9'd1, 8'h00}},
        '{0, lfr_pkg::ACT_LOAD,  8'd1, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_OK, 9'd0, 9'd2, 8'h00}},
        '{0, lfr_pkg::ACT_READ,  8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_OK, 9'd0, 9'd2, 8'hFF}},
        '{0, lfr_pkg::ACT_READ,  8'd1, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_OK, 9'd0, 9'd2, 8'h00}},
        // The zero byte is deleted by an empty replacement.
        '{0, lfr_pkg::ACT_SUBST, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 1,
          '{lfr_pkg::ST_REPLACED, 9'd1, 9'd1, 8'h00}},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO,  64'h6261,   0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_LEN, 64'd2,      0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_NEW_LO,  64'h5A5958, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_NEW_LEN, 64'd3,      0, NO_RES},
        '{0, lfr_pkg::ACT_LOAD, 8'd0, 8'h61, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{0, lfr_pkg::ACT_LOAD, 8'd1, 8'h62, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{0, lfr_pkg::ACT_LOAD, 8'd2, 8'h61, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{0, lfr_pkg::ACT_LOAD, 8'd3, 8'h62, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{0, lfr_pkg::ACT_SUBST, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        // The second copy ends exactly at the line end.
        '{0, lfr_pkg::ACT_SUBST, 8'd3, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_LEN, 64'd0,  0, NO_RES},
        '{0, lfr_pkg::ACT_SUBST, 8'd2, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_LEN, 64'd31, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_NEW_LEN, 64'd31, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_HI,  '1,     0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_NEW_HI,  '1,     0, NO_RES},
        '{0, lfr_pkg::ACT_SUBST, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_OLD_LEN, 64'd0,  0, NO_RES},
        '{1, lfr_pkg::ACT_LOAD, 8'd0, 8'h00, lfr_pkg::REG_MAX_LEN, 64'd1,  0, NO_RES},
        // Any insertion now reaches the length limit.
        '{0, lfr_pkg::ACT_SUBST, 8'd0, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES},
        '{0, lfr_pkg::ACT_READ, 8'd255, 8'h00, lfr_pkg::REG_OLD_LO, 64'd0, 0, NO_RES}
    };

    initial begin
        int phase, build_len, ops, sel, hole;
        logic [7:0] pos;
        line_len = 0;
        old_word = '0;
        new_word = '0;
        old_len_reg = 5'd1;
        new_len_reg = 5'd0;
        max_len_reg = 9'd256;
        for (int i = 0; i < 256; i++) begin
            line_bytes[i] = '0;
            line_written[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 70;
        foreach (directed[n]) begin
            if (directed[n].is_cfg) begin
                wait_idle();
                write_reg(directed[n].cfg_index, directed[n].cfg_data);
            end else begin
                send_item(directed[n].action, directed[n].position, directed[n].byte_in,
                          directed[n].typed, directed[n].res);
            end
        end

        // Random phases: a new configuration, a freshly built line, then a
        // mix of operations on it.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 4) begin
                send_idle_pct = 9;
                recv_idle_pct = 70;
            end else if (phase < 8) begin
                send_idle_pct = 70;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_reg(lfr_pkg::REG_OLD_LO, alpha_bytes());
            write_reg(lfr_pkg::REG_OLD_HI, alpha_bytes());
            write_reg(lfr_pkg::REG_OLD_LEN,
                      ($urandom_range(3) == 0) ? rand_len() : $urandom_range(1, 3));
            write_reg(lfr_pkg::REG_NEW_LO, alpha_bytes());
            write_reg(lfr_pkg::REG_NEW_HI, alpha_bytes());
            write_reg(lfr_pkg::REG_NEW_LEN, rand_len());
            case ($urandom_range(3))
                0:       write_reg(lfr_pkg::REG_MAX_LEN, 64'd1);
                1:       write_reg(lfr_pkg::REG_MAX_LEN, $urandom_range(1, 256));
                default: write_reg(lfr_pkg::REG_MAX_LEN, 64'd256);
            endcase
            // Let the output back up in a couple of phases while items keep coming.
            if (phase == 2 || phase == 6) hold_req = 1;
            build_len = (phase == 5) ? 256 : $urandom_range(1, 24);
            for (int i = 0; i < build_len; i++)
                send_item(lfr_pkg::ACT_LOAD, 8'(i), alpha_byte(), 0, NO_RES);
            ops = 22;
            for (int n = 0; n < ops; n++) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    pos = ($urandom_range(9) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(line_len + 1));
                    send_item(lfr_pkg::ACT_SUBST, pos, 8'($urandom), 0, NO_RES);
                end else if (sel < 70) begin
                    pos = ($urandom_range(4) == 0) ? 8'($urandom)
                          : 8'($urandom_range(line_len == 0 ? 0 : line_len - 1));
                    send_item(lfr_pkg::ACT_READ, pos, 8'($urandom), 0, NO_RES);
                end else if (sel < 92) begin
                    hole = first_hole();
                    send_item(lfr_pkg::ACT_LOAD, 8'($urandom_range(hole)), 8'($urandom),
                              0, NO_RES);
                end else begin
                    send_item(ACT_BAD, 8'($urandom), 8'($urandom), 0, NO_RES);
                end
            end
            phase++;
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
